### rtl/core/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Types and codes for the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

   // operation kinds
   localparam logic [2:0] K_HEAD   = 3'd0;
   localparam logic [2:0] K_TAIL   = 3'd1;
   localparam logic [2:0] K_INSERT = 3'd2;
   localparam logic [2:0] K_REMOVE = 3'd3;
   localparam logic [2:0] K_LIST   = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   // a list request never returns more than this many elements
   localparam int LIST_LIMIT = 16;

   typedef struct packed {
      logic [2:0]         kind;
      logic [7:0]         position;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] element;
      logic [4:0]         count;
      logic               last;
   } rsp_type;

endpackage

### rtl/core/pol_ram.sv
// ----------------------------------------------------------------------------
// pol_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/positional_ordered_list.sv
// ----------------------------------------------------------------------------
// positional_ordered_list
// Ordered list of signed 32-bit values with positional insert and remove.
// ----------------------------------------------------------------------------
// The list lives in a single element RAM (head at address 0) plus a count
// register. A transaction is taken when start is high and busy is low; its
// results appear in the cycle after the final step, each for exactly one cycle
// with rsp_strobe high, and the receiver cannot hold them off. Because the RAM
// has one write port, every element that has to move takes a step of its own:
//   - append, or remove of the tail element, and any rejected or unused
//     request: nothing moves, next transaction may follow immediately;
//   - insert before position p with n elements held: n - p moves, then a put;
//   - remove at position p: n - p - 1 moves;
//   - list all: min(n, 16) elements, results streamed back to back with
//     last on the final one (one status result on an empty list).
// RAM contents need no clearing after reset; only entries below the count
// are ever read.
// ----------------------------------------------------------------------------
module positional_ordered_list #(
   parameter int CAPACITY = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pol_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pol_pkg::rsp_type rsp_data
);
   import pol_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > 8) ? CW : 8;   // width for position/count compares

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_UP   = 3'd1;   // shifting towards the tail
   localparam logic [2:0] S_PUT  = 3'd2;   // write the new value into the gap
   localparam logic [2:0] S_DOWN = 3'd3;   // shifting towards the head
   localparam logic [2:0] S_LIST = 3'd4;   // streaming elements out

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] src_ff, src_in;   // address read in the previous cycle
   logic [AW-1:0] pa_ff, pa_in;     // insert position
   logic [31:0]   val_ff, val_in;
   logic [CW-1:0] lim_ff, lim_in;   // number of elements to list
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0]   wr_data, rd_data;

   logic [XW-1:0] pos_x, cnt_x;
   logic [AW-1:0] tail_addr;

   pol_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_elements (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign cnt_x     = XW'(cnt_ff);
   assign tail_addr = AW'(cnt_ff - CW'(1));

   // effective position for the insert kinds
   always_comb begin
      case (req_data.kind)
         K_HEAD:  pos_x = '0;
         K_TAIL:  pos_x = cnt_x;
         default: pos_x = XW'(req_data.position);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      src_in       = src_ff;
      pa_in        = pa_ff;
      val_in       = val_ff;
      lim_in       = lim_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = src_ff;
      wr_data      = rd_data;
      rd_en        = 1'b0;
      rd_addr      = src_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_in.status  = ST_OK;
               rsp_in.element = '0;
               rsp_in.count   = 5'(cnt_ff);
               rsp_in.last    = 1'b1;
               case (req_data.kind) inside
                  K_HEAD, K_TAIL, K_INSERT: begin
                     if (pos_x > cnt_x) begin
                        rsp_in.status = ST_BADPOS;
                        rsp_valid_in  = 1'b1;
                     end else if (cnt_ff >= CW'(CAPACITY)) begin
                        rsp_in.status = ST_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (pos_x == cnt_x) begin
                        // append: nothing moves
                        wr_en         = 1'b1;
                        wr_addr       = AW'(pos_x);
                        wr_data       = 32'(req_data.value);
                        cnt_in        = cnt_ff + CW'(1);
                        rsp_in.count  = 5'(cnt_ff + CW'(1));
                        rsp_valid_in  = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = tail_addr;
                        src_in   = tail_addr;
                        pa_in    = AW'(pos_x);
                        val_in   = 32'(req_data.value);
                        state_in = S_UP;
                     end
                  end
                  K_REMOVE: begin
                     if (cnt_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else if (XW'(req_data.position) >= cnt_x) begin
                        rsp_in.status = ST_BADPOS;
                        rsp_valid_in  = 1'b1;
                     end else if (AW'(req_data.position) == tail_addr) begin
                        // tail element: just drop it
                        cnt_in       = cnt_ff - CW'(1);
                        rsp_in.count = 5'(cnt_ff - CW'(1));
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = AW'(req_data.position) + AW'(1);
                        src_in   = AW'(req_data.position) + AW'(1);
                        state_in = S_DOWN;
                     end
                  end
                  K_LIST: begin
                     if (cnt_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        rsp_in.count  = '0;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        src_in   = '0;
                        lim_in   = (int'(cnt_ff) < LIST_LIMIT) ? cnt_ff : CW'(LIST_LIMIT);
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;   // unused kind: status only
                  end
               endcase
            end
         end
         S_UP: begin
            wr_en   = 1'b1;
            wr_addr = src_ff + AW'(1);
            wr_data = rd_data;
            if (src_ff == pa_ff) begin
               state_in = S_PUT;
            end else begin
               rd_en   = 1'b1;
               rd_addr = src_ff - AW'(1);
               src_in  = src_ff - AW'(1);
            end
         end
         S_PUT: begin
            wr_en          = 1'b1;
            wr_addr        = pa_ff;
            wr_data        = val_ff;
            cnt_in         = cnt_ff + CW'(1);
            rsp_in.status  = ST_OK;
            rsp_in.element = '0;
            rsp_in.count   = 5'(cnt_ff + CW'(1));
            rsp_in.last    = 1'b1;
            rsp_valid_in   = 1'b1;
            state_in       = S_IDLE;
         end
         S_DOWN: begin
            wr_en   = 1'b1;
            wr_addr = src_ff - AW'(1);
            wr_data = rd_data;
            if (src_ff == tail_addr) begin
               cnt_in         = cnt_ff - CW'(1);
               rsp_in.status  = ST_OK;
               rsp_in.element = '0;
               rsp_in.count   = 5'(cnt_ff - CW'(1));
               rsp_in.last    = 1'b1;
               rsp_valid_in   = 1'b1;
               state_in       = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = src_ff + AW'(1);
               src_in  = src_ff + AW'(1);
            end
         end
         S_LIST: begin
            rsp_in.status  = ST_OK;
            rsp_in.element = rd_data;
            rsp_in.count   = 5'(cnt_ff);
            rsp_in.last    = (CW'(src_ff) + CW'(1)) == lim_ff;
            rsp_valid_in   = 1'b1;
            if ((CW'(src_ff) + CW'(1)) == lim_ff) begin
               state_in = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = src_ff + AW'(1);
               src_in  = src_ff + AW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      src_ff <= src_in;
      pa_ff  <= pa_in;
      val_ff <= val_in;
      lim_ff <= lim_in;
      rsp_ff <= rsp_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // ---- checks ----
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= CAPACITY)
      else $error("element count above capacity");

   a_status_final: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_data.status != ST_OK) |-> rsp_data.last && (rsp_data.element == '0))
      else $error("error status not a final, element-free transaction");

   a_list_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe && busy == (state_ff == S_LIST))
      else $error("list burst broken");

   a_list_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIST) |=> rsp_strobe)
      else $error("list step gave no result");

endmodule
